// File: design/chroma_420_bilinear_upsampler_macros.svh
// Assertion macros shared by the checker.
`ifndef CHROMA_420_BILINEAR_UPSAMPLER_MACROS_SVH
`define CHROMA_420_BILINEAR_UPSAMPLER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define C420_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define C420_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: design/c420_pkg.sv
// ----------------------------------------------------------------------------
// c420_pkg
// Shared types and constants of the chroma 4:2:0 upsampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package c420_pkg;
  localparam int unsigned DefMaxWidth   = 4096;
  localparam int unsigned DefMaxHeight  = 16384;
  localparam int unsigned DefSampleBits = 16;
  localparam int unsigned CfgIdxBits    = 1;
  localparam int unsigned CfgDataBits   = 15;
  localparam logic [CfgIdxBits-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegHeight = 1'b1;

  // Job for one input word: the four neighbours and the tap sets along each axis.
  typedef struct packed {
    logic [31:0] p00;
    logic [31:0] p01;
    logic [31:0] p10;
    logic [31:0] p11;
    logic [11:0] cx;      // chroma column
    logic [13:0] cy;      // chroma row
    logic        x_edge;  // column zero
    logic        y_edge;
    logic        x_tail;  // extra copied column at the right border
    logic        y_tail;
    logic        fend;
  } job_t;
endpackage

// File: design/c420_front.sv
// ----------------------------------------------------------------------------
// c420_front
// Accepts chroma words, tracks position, keeps the line store and neighbours.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module c420_front import c420_pkg::*; #(
  parameter int unsigned MaxWidth   = DefMaxWidth,
  parameter int unsigned MaxHeight  = DefMaxHeight,
  parameter int unsigned SampleBits = DefSampleBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [31:0]            in_data_i,
  output logic                   job_valid_o,
  input  logic                   job_ready_i,
  output job_t                   job_o
);
  localparam int unsigned Depth = (MaxWidth + 1) / 2;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [12:0] width_q;
  logic [14:0] height_q;
  logic [12:0] cx_q;
  logic [13:0] cy_q;
  logic [31:0] left_q, aleft_q;
  logic [31:0] mem [Depth];
  logic [31:0] rd_q;
  // Stage 1 holds the accepted word while the store read completes.
  logic        s1_v_q;
  logic [31:0] s1_cur_q;
  logic [12:0] s1_cx_q;
  logic [13:0] s1_cy_q;
  logic        s1_lc_q, s1_lr_q, s1_xt_q, s1_yt_q;
  logic        out_v_q;
  job_t        out_q;

  logic [13:0] w_eff;
  logic [15:0] h_eff;
  logic [12:0] cw;
  logic [14:0] chh;
  logic [12:0] cx_n;
  logic [13:0] cy_n;
  logic        acc, adv, lc, lr;
  logic [15:0] smask;
  logic [31:0] cur;

  always_comb begin
    w_eff = (width_q == '0) ? 14'd1 :
            ({1'b0, width_q} > 14'(MaxWidth)) ? 14'(MaxWidth) : {1'b0, width_q};
    h_eff = (height_q == '0) ? 16'd1 :
            ({1'b0, height_q} > 16'(MaxHeight)) ? 16'(MaxHeight) : {1'b0, height_q};
    cw    = 13'((w_eff + 14'd1) >> 1);
    chh   = 15'((h_eff + 16'd1) >> 1);
    cx_n  = (cx_q >= cw) ? '0 : cx_q;
    cy_n  = ({1'b0, cy_q} >= chh) ? '0 : cy_q;
    lc    = (cx_n + 13'd1 == cw);
    lr    = ({1'b0, cy_n} + 15'd1 == chh);
    smask = 16'((32'd1 << SampleBits) - 32'd1);
    cur   = {in_data_i[31:16] & smask, in_data_i[15:0] & smask};
  end

  // Output register frees when taken; stage 1 moves on when it is free.
  assign adv        = s1_v_q && (!out_v_q || job_ready_i);
  assign in_ready_o = !s1_v_q || adv;
  assign acc        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem[cx_n[AW-1:0]] <= cur;
      rd_q <= mem[cx_n[AW-1:0]];
      s1_cur_q <= cur;
      s1_cx_q  <= cx_n;
      s1_cy_q  <= cy_n;
      s1_lc_q  <= lc;
      s1_lr_q  <= lr;
      s1_xt_q  <= lc && !w_eff[0];
      s1_yt_q  <= lr && !h_eff[0];
    end
    if (adv) begin
      out_q.p00    <= aleft_q;
      out_q.p01    <= (s1_cy_q == '0) ? 32'd0 : rd_q;
      out_q.p10    <= left_q;
      out_q.p11    <= s1_cur_q;
      out_q.cx     <= s1_cx_q[11:0];
      out_q.cy     <= s1_cy_q;
      out_q.x_edge <= (s1_cx_q == '0);
      out_q.y_edge <= (s1_cy_q == '0);
      out_q.x_tail <= s1_xt_q;
      out_q.y_tail <= s1_yt_q;
      out_q.fend   <= s1_lc_q && s1_lr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1920;
      height_q <= 15'd1080;
      cx_q     <= '0;
      cy_q     <= '0;
      left_q   <= '0;
      aleft_q  <= '0;
      s1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegWidth) width_q <= cfg_data_i[12:0];
        else                       height_q <= cfg_data_i;
        cx_q <= '0;
        cy_q <= '0;
      end else if (acc) begin
        cx_q <= lc ? '0 : cx_n + 13'd1;
        cy_q <= lc ? (lr ? '0 : cy_n + 14'd1) : cy_n;
      end
      if (adv) begin
        aleft_q      <= (s1_cy_q == '0) ? 32'd0 : rd_q;
        left_q       <= s1_cur_q;
        out_v_q      <= 1'b1;
      end else if (job_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (acc) s1_v_q <= 1'b1;
      else if (adv) s1_v_q <= 1'b0;
    end
  end

  assign job_valid_o = out_v_q;
  assign job_o       = out_q;
endmodule

// File: design/c420_fifo.sv
// ----------------------------------------------------------------------------
// c420_fifo
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module c420_fifo import c420_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// File: design/c420_back.sv
// ----------------------------------------------------------------------------
// c420_back
// Walks the output taps of one job and produces one pixel per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module c420_back import c420_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [63:0] m_data_o,
  output logic [1:0]  m_user_o
);
  logic [1:0] ix_q, iy_q;
  logic [1:0] nx, ny;
  logic       last_tap, fire, ov_q, take;
  logic [63:0] od_q;
  logic [1:0]  ou_q;
  logic        ix_int, iy_int;
  logic [1:0]  wxp, wxc, wyp, wyc;
  logic [11:0] px;
  logic [13:0] py;
  logic [15:0] cb, cr;

  function automatic logic [15:0] mix(input logic ii, input logic jj,
      input logic [1:0] xp, input logic [1:0] xc, input logic [1:0] yp,
      input logic [1:0] yc, input logic [15:0] a, input logic [15:0] b,
      input logic [15:0] l, input logic [15:0] c);
    logic [21:0] s;
    s = '0;
    if (ii && jj) begin
      s = 22'(yp) * 22'(xp) * 22'(a) + 22'(yp) * 22'(xc) * 22'(b) +
          22'(yc) * 22'(xp) * 22'(l) + 22'(yc) * 22'(xc) * 22'(c) + 22'd8;
      mix = s[19:4];
    end else if (ii) begin
      s = 22'(xp) * 22'(l) + 22'(xc) * 22'(c) + 22'd2;
      mix = s[17:2];
    end else if (jj) begin
      s = 22'(yp) * 22'(b) + 22'(yc) * 22'(c) + 22'd2;
      mix = s[17:2];
    end else begin
      mix = c;
    end
  endfunction

  always_comb begin
    nx = (job_i.x_edge ? 2'd1 : 2'd2) + {1'b0, job_i.x_tail};
    ny = (job_i.y_edge ? 2'd1 : 2'd2) + {1'b0, job_i.y_tail};
    // Tap 0 and 1 of a non-border index interpolate; tap order matches row-major.
    ix_int = !job_i.x_edge && (ix_q != 2'd2);
    iy_int = !job_i.y_edge && (iy_q != 2'd2);
    wxp = (ix_q == 2'd0) ? 2'd3 : 2'd1;
    wxc = (ix_q == 2'd0) ? 2'd1 : 2'd3;
    wyp = (iy_q == 2'd0) ? 2'd3 : 2'd1;
    wyc = (iy_q == 2'd0) ? 2'd1 : 2'd3;
    px = job_i.x_edge ? 12'({1'b0, ix_q}) : 12'({job_i.cx, 1'b0} - 13'd1 + 13'(ix_q));
    py = job_i.y_edge ? 14'({1'b0, iy_q}) : 14'({job_i.cy, 1'b0} - 15'd1 + 15'(iy_q));
    if (job_i.x_edge && ix_q != 2'd0) ix_int = 1'b0;
    if (job_i.y_edge && iy_q != 2'd0) iy_int = 1'b0;
    cb = mix(ix_int, iy_int, wxp, wxc, wyp, wyc, job_i.p00[15:0], job_i.p01[15:0],
             job_i.p10[15:0], job_i.p11[15:0]);
    cr = mix(ix_int, iy_int, wxp, wxc, wyp, wyc, job_i.p00[31:16], job_i.p01[31:16],
             job_i.p10[31:16], job_i.p11[31:16]);
    last_tap = (ix_q + 2'd1 == nx) && (iy_q + 2'd1 == ny);
  end

  assign take        = !ov_q || m_ready_i;
  assign fire        = job_valid_i && take;
  assign job_ready_o = fire && last_tap;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      od_q <= {6'd0, cr, cb, py, px};
      ou_q <= {last_tap && job_i.fend, last_tap};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_q <= '0;
      iy_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (fire) begin
        ov_q <= 1'b1;
        if (last_tap) begin
          ix_q <= '0;
          iy_q <= '0;
        end else if (ix_q + 2'd1 == nx) begin
          ix_q <= '0;
          iy_q <= iy_q + 2'd1;
        end else begin
          ix_q <= ix_q + 2'd1;
        end
      end else if (m_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = ov_q;
  assign m_data_o  = od_q;
  assign m_user_o  = ou_q;
endmodule

// File: design/chroma_420_bilinear_upsampler.sv
// ----------------------------------------------------------------------------
// chroma_420_bilinear_upsampler
// Bilinear 4:2:0 to 4:4:4 chroma upsampling with coordinate tags.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata: sample_cb[15:0], sample_cr[31:16]
// m_axis    out  tdata: pixel_x, pixel_y, pixel_cb, pixel_cr; tuser: last_of_run, frame_end
// cfg       in   write enable, index, data
// Each input word yields 1 to 9 pixels, one pixel per cycle from the back part
// whenever a job is waiting and the output is not stalled.
// The front part registers the line store read when it accepts a word.
// Reset is asynchronous active low; the line store needs no clearing.
// Output stalls fill the job queue, then hold off the input.
`timescale 1ns / 1ps
module chroma_420_bilinear_upsampler import c420_pkg::*; #(
  parameter int unsigned MaxWidth   = DefMaxWidth,
  parameter int unsigned MaxHeight  = DefMaxHeight,
  parameter int unsigned SampleBits = DefSampleBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,   // sample_cb, sample_cr
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [63:0]            m_axis_tdata,   // pixel_x, pixel_y, pixel_cb, pixel_cr
  output logic [1:0]             m_axis_tuser    // last_of_run, frame_end
);
  logic fj_v, fj_r, bj_v, bj_r;
  job_t fj, bj;

  c420_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight), .SampleBits(SampleBits))
    u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .job_valid_o(fj_v), .job_ready_i(fj_r), .job_o(fj));

  c420_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(fj_v), .wr_ready_o(fj_r), .wr_data_i(fj),
    .rd_valid_o(bj_v), .rd_ready_i(bj_r), .rd_data_o(bj));

  c420_back u_back (
    .clk_i, .rst_ni, .job_valid_i(bj_v), .job_ready_o(bj_r), .job_i(bj),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_o(m_axis_tdata), .m_user_o(m_axis_tuser));
endmodule

// File: design/c420_checker.sv
// ----------------------------------------------------------------------------
// c420_checker
// Port-level checks of the upsampler output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chroma_420_bilinear_upsampler_macros.svh"
module c420_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  // A frame end always closes a run.
  `C420_ASSERT_IMP(a_fend_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])
  // A stalled word keeps its payload.
  `C420_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid)
  // Padding bits stay zero.
  `C420_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[63:58] == 6'd0)
endmodule

bind chroma_420_bilinear_upsampler c420_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser);

// File: bench/chroma_420_bilinear_upsampler_tb.sv
// ----------------------------------------------------------------------------
// chroma_420_bilinear_upsampler_tb
// Streams 4:2:0 chroma frames of many sizes into the upsampler. A bit-exact
// bilinear predictor computes every tagged 4:4:4 pixel, and each output word
// is checked against it under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chroma_420_bilinear_upsampler_tb;
  import c420_pkg::*;

  typedef struct {
    int unsigned pos;
    bit          interp;
    int unsigned wprev;
    int unsigned wcur;
  } tap_t;

  typedef struct {
    logic [11:0] x;
    logic [13:0] y;
    logic [15:0] cb;
    logic [15:0] cr;
    logic        run_last;
    logic        frm_end;
  } pixel_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i = RegWidth;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [31:0]            s_axis_tdata = '0;   // sample_cb, sample_cr
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [63:0]            m_axis_tdata;        // pixel_x, pixel_y, pixel_cb, pixel_cr
  logic [1:0]             m_axis_tuser;        // last_of_run, frame_end

  chroma_420_bilinear_upsampler DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state.
  logic [31:0] row_store [2048];
  logic [31:0] left_px, above_left_px;
  int unsigned chroma_col, chroma_row, width_reg, height_reg;

  logic [31:0] sample_q [$];
  pixel_t      pixel_q [$];
  int          words_sent, words_taken, mismatches, items_total;
  int          send_idle_pct, recv_stall_pct, hold_cycles;
  bit          word_taken;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned bound);
    if (v == 0) return 1;
    if (v > bound) return bound;
    return v;
  endfunction

  function automatic int tap_count(int unsigned c, int unsigned cn, int unsigned n);
    return ((c == 0) ? 1 : 2) + ((c + 1 == cn && n[0] == 1'b0) ? 1 : 0);
  endfunction

  function automatic tap_t tap_at(int unsigned c, int k);
    tap_t t;
    int   base;
    base = (c == 0) ? 1 : 2;
    t = '{pos: 0, interp: 0, wprev: 0, wcur: 0};
    if (k >= base) begin
      // Right or bottom border copy of the last chroma sample.
      t.pos = 2 * c + 1;
    end else if (c == 0) begin
      t.pos = 0;
    end else if (k == 0) begin
      t = '{pos: 2 * c - 1, interp: 1, wprev: 3, wcur: 1};
    end else begin
      t = '{pos: 2 * c, interp: 1, wprev: 1, wcur: 3};
    end
    return t;
  endfunction

  function automatic logic [15:0] blend(tap_t ty, tap_t tx, int unsigned p00,
                                        int unsigned p01, int unsigned p10,
                                        int unsigned p11);
    int unsigned s;
    if (ty.interp && tx.interp)
      s = (ty.wprev * tx.wprev * p00 + ty.wprev * tx.wcur * p01 +
           ty.wcur * tx.wprev * p10 + ty.wcur * tx.wcur * p11 + 8) >> 4;
    else if (tx.interp)
      s = (tx.wprev * p10 + tx.wcur * p11 + 2) >> 2;
    else if (ty.interp)
      s = (ty.wprev * p01 + ty.wcur * p11 + 2) >> 2;
    else
      s = p11;
    return s[15:0];
  endfunction

  task automatic predict_pixels(input logic [31:0] cur);
    int unsigned w, h, cw, ch;
    int          nx, ny, n;
    logic [31:0] above;
    tap_t        tx, ty;
    pixel_t      p [9];
    w = clamp_size(width_reg, DefMaxWidth);
    h = clamp_size(height_reg, DefMaxHeight);
    cw = (w + 1) / 2;
    ch = (h + 1) / 2;
    if (chroma_col >= cw) chroma_col = 0;
    if (chroma_row >= ch) chroma_row = 0;
    above = (chroma_row != 0) ? row_store[chroma_col] : 32'd0;
    nx = tap_count(chroma_col, cw, w);
    ny = tap_count(chroma_row, ch, h);
    n = 0;
    for (int j = 0; j < ny; j++) begin
      for (int i = 0; i < nx; i++) begin
        ty = tap_at(chroma_row, j);
        tx = tap_at(chroma_col, i);
        p[n].x = tx.pos[11:0];
        p[n].y = ty.pos[13:0];
        p[n].cb = blend(ty, tx, above_left_px[15:0], above[15:0], left_px[15:0], cur[15:0]);
        p[n].cr = blend(ty, tx, above_left_px[31:16], above[31:16], left_px[31:16],
                        cur[31:16]);
        p[n].run_last = 1'b0;
        p[n].frm_end = 1'b0;
        n++;
      end
    end
    p[n-1].run_last = 1'b1;
    p[n-1].frm_end = (chroma_col + 1 == cw) && (chroma_row + 1 == ch);
    for (int k = 0; k < n; k++) pixel_q = {pixel_q, p[k]};
    above_left_px = above;
    left_px = cur;
    row_store[chroma_col] = cur;
    if (chroma_col + 1 == cw) begin
      chroma_col = 0;
      chroma_row = (chroma_row + 1 == ch) ? 0 : chroma_row + 1;
    end else begin
      chroma_col++;
    end
  endtask

  // Input side: acceptance at the rising edge, new word at the falling edge.
  always @(posedge clk_i) begin
    word_taken = s_axis_tvalid && s_axis_tready;
    if (word_taken) begin
      predict_pixels(s_axis_tdata);
      words_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output checker.
  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        e = pixel_q.pop_front();
        if (m_axis_tdata[11:0] !== e.x || m_axis_tdata[25:12] !== e.y ||
            m_axis_tdata[41:26] !== e.cb || m_axis_tdata[57:42] !== e.cr ||
            m_axis_tuser[0] !== e.run_last || m_axis_tuser[1] !== e.frm_end) begin
          if (mismatches < 10)
            $display({"mismatch: exp x=%0d y=%0d cb=%h cr=%h last=%b end=%b, ",
                      "got x=%0d y=%0d cb=%h cr=%h last=%b end=%b"},
                     e.x, e.y, e.cb, e.cr, e.run_last, e.frm_end,
                     m_axis_tdata[11:0], m_axis_tdata[25:12], m_axis_tdata[41:26],
                     m_axis_tdata[57:42], m_axis_tuser[0], m_axis_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CfgDataBits-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegWidth) width_reg = value & 32'h1FFF;
    else height_reg = value & 32'h7FFF;
    chroma_col = 0;
    chroma_row = 0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (words_taken != words_sent || pixel_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic queue_word(input logic [31:0] word);
    sample_q = {sample_q, word};
    words_sent++;
    items_total++;
  endtask

  // Sets a frame size and feeds n chroma samples with random content.
  task automatic run_frame(input int unsigned w, input int unsigned h, input int n);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    for (int k = 0; k < n; k++) queue_word($urandom);
    wait_drained();
  endtask

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned w, h, cw, ch;
    int          n;
    left_px = '0;
    above_left_px = '0;
    chroma_col = 0;
    chroma_row = 0;
    width_reg = 1920;
    height_reg = 1080;
    words_sent = 0;
    words_taken = 0;
    mismatches = 0;
    items_total = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset size, then sample extremes in a small even frame.
    queue_word(32'h0000_0000);
    queue_word(32'hFFFF_FFFF);
    queue_word(32'h0000_FFFF);
    wait_drained();
    write_reg(RegWidth, 4);
    write_reg(RegHeight, 4);
    queue_word(32'hFFFF_0000);
    queue_word(32'h0000_FFFF);
    queue_word(32'hFFFF_FFFF);
    queue_word(32'h0000_0000);
    wait_drained();
    run_frame(5, 3, 6);       // odd sizes, frame wraps after six samples
    run_frame(0, 0, 2);       // zero size acts as one
    run_frame(8191, 2, 3);    // oversize width saturates
    run_frame(1, 32767, 3);   // oversize height saturates
    run_frame(4096, 16384, 2);
    run_frame(2, 1, 2);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 0) begin
        // Long receiver hold-off while the sender keeps offering samples.
        write_reg(RegWidth, 8);
        write_reg(RegHeight, 8);
        hold_cycles = 400;
        for (int k = 0; k < 16; k++) queue_word($urandom);
        wait_drained();
      end
      while (items_total < 10 + 100 * (ph + 1)) begin
        w = $urandom_range(12, 1);
        h = $urandom_range(10, 1);
        if ($urandom_range(9) == 0) w = $urandom_range(1, 0);
        cw = (w == 0) ? 1 : (w + 1) / 2;
        ch = (h + 1) / 2;
        n = cw * ch;
        // Most frames are whole; a few stop early or run into the next frame.
        if ($urandom_range(4) == 0) n = $urandom_range(2 * n, 1);
        run_frame(w, h, n);
      end
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
